// File: sv/escrle_pkg.sv
// Shared types and constants of the escape run-length byte decoder.
package escrle_pkg;

   // Field widths fixed by the word formats
   localparam int ByteWidth  = 8;
   localparam int TotalWidth = 26;
   localparam int CapWidth   = 26;

   // Byte that opens an escape sequence
   localparam logic [ByteWidth-1:0] EscapeByte = 8'hFF;

   // Output capacity after reset
   localparam logic [31:0] CapReset = 32'd33554432;

   typedef logic [CapWidth-1:0] csr_word_type;

   typedef struct packed {
      logic [ByteWidth-1:0] in_byte;
      logic                 last_byte;
   } req_word_type;

   typedef struct packed {
      logic [ByteWidth-1:0]  out_value;
      logic [ByteWidth-1:0]  run_length;
      logic [TotalWidth-1:0] total_written;
      logic                  stream_end;
   } rsp_word_type;

   // What the decode step hands to the result register
   typedef struct packed {
      logic         emit;
      rsp_word_type word;
   } step_type;

endpackage

// File: sv/escrle_chan_if.sv
// Valid/ready channel carrying one word of a chosen payload type.
interface escrle_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: sv/escrle_in_reg.sv
// Input register: holds one request word until the decode step takes it.
module escrle_in_reg (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  escrle_pkg::req_word_type in_word,
   output logic                    in_ready,
   input  logic                    take,
   output logic                    held_valid,
   output escrle_pkg::req_word_type held_word
);
   import escrle_pkg::*;

   logic         valid_ff;
   req_word_type word_ff;

   // Accept a new word when empty or when the held one leaves this cycle
   assign in_ready   = !valid_ff || take;
   assign held_valid = valid_ff;
   assign held_word  = word_ff;

   // Hold the word; the payload needs no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         word_ff <= in_word;
      end
   end

endmodule

// File: sv/escrle_core.sv
// Decode step: parse phase, pending count, written count and capacity register.
module escrle_core #(
   parameter int COUNT_WIDTH = 26
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write,
   input  escrle_pkg::csr_word_type csr_data,
   input  logic                     fire,
   input  escrle_pkg::req_word_type item,
   output escrle_pkg::step_type     step
);
   import escrle_pkg::*;

   localparam int WideWidth = 33;
   localparam logic [COUNT_WIDTH-1:0] CapResetValue = COUNT_WIDTH'(CapReset);

   typedef enum logic [1:0] {
      PH_LITERAL,
      PH_COUNT,
      PH_VALUE
   } phase_type;

   phase_type               phase_ff, phase_in, phase_upd;
   logic [ByteWidth-1:0]    held_ff, held_in, held_upd;
   logic [COUNT_WIDTH-1:0]  written_ff, written_in, written_upd;
   logic [COUNT_WIDTH-1:0]  cap_ff, cap_in;

   logic                    not_full;
   logic [COUNT_WIDTH-1:0]  room;
   logic [WideWidth-1:0]    held_wide, room_wide, cut_wide;
   logic [31:0]             csr_wide, written_wide;
   logic                    have;
   logic [ByteWidth-1:0]    value, run;

   // Widen the write data, then keep the counter width
   assign csr_wide = 32'(csr_data);
   assign cap_in   = csr_wide[COUNT_WIDTH-1:0];

   // Space left and the run cut to it
   assign not_full  = written_ff < cap_ff;
   assign room      = cap_ff - written_ff;
   assign held_wide = WideWidth'(held_ff);
   assign room_wide = WideWidth'(room);
   assign cut_wide  = (held_wide < room_wide) ? held_wide : room_wide;

   // Parse one byte; a full output ignores it
   always_comb begin
      phase_upd   = phase_ff;
      held_upd    = held_ff;
      written_upd = written_ff;
      have        = 1'b0;
      value       = '0;
      run         = '0;
      if (not_full) begin
         case (phase_ff)
            PH_COUNT: begin
               held_upd  = item.in_byte;
               phase_upd = PH_VALUE;
            end
            PH_VALUE: begin
               value       = item.in_byte;
               run         = cut_wide[ByteWidth-1:0];
               written_upd = written_ff + COUNT_WIDTH'(cut_wide);
               phase_upd   = PH_LITERAL;
               have        = 1'b1;
            end
            default: begin
               if (item.in_byte == EscapeByte) begin
                  phase_upd = PH_COUNT;
               end else begin
                  value       = item.in_byte;
                  run         = ByteWidth'(1);
                  written_upd = written_ff + COUNT_WIDTH'(1);
                  phase_upd   = PH_LITERAL;
                  have        = 1'b1;
               end
            end
         endcase
      end
   end

   // Clear the stream state after the last byte
   assign phase_in   = item.last_byte ? PH_LITERAL : phase_upd;
   assign held_in    = item.last_byte ? '0 : held_upd;
   assign written_in = item.last_byte ? '0 : written_upd;

   // Build the result word; an end marker without data carries a zero value and run length
   assign written_wide            = 32'(written_upd);
   assign step.emit               = have || item.last_byte;
   assign step.word.out_value     = value;
   assign step.word.run_length    = run;
   assign step.word.total_written = written_wide[TotalWidth-1:0];
   assign step.word.stream_end    = item.last_byte;

   // Hold state; advance on each word taken from the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff     <= CapResetValue;
         phase_ff   <= PH_LITERAL;
         held_ff    <= '0;
         written_ff <= '0;
      end else begin
         if (csr_write) begin
            cap_ff <= cap_in;
         end
         if (fire) begin
            phase_ff   <= phase_in;
            held_ff    <= held_in;
            written_ff <= written_in;
         end
      end
   end

endmodule

// File: sv/escrle_out_reg.sv
// Result register: holds one response word until the receiver takes it.
module escrle_out_reg (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  escrle_pkg::rsp_word_type load_word,
   output logic                    free,
   output logic                    out_valid,
   output escrle_pkg::rsp_word_type out_word,
   input  logic                    out_ready
);
   import escrle_pkg::*;

   logic         valid_ff;
   rsp_word_type word_ff;

   // Room for a new word when empty or when the held one is taken now
   assign free      = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (free) begin
         valid_ff <= load;
      end
   end

   // Hold the payload while stalled
   always_ff @(posedge clock) begin
      if (free && load) begin
         word_ff <= load_word;
      end
   end

endmodule

// File: sv/escape_rle_byte_decoder.sv
// Top level of the escape run-length byte decoder.
//
// Usage:
//   req_chan carries one encoded byte per word with a last_byte flag. A byte
//   other than 0xFF gives one response with run_length 1. 0xFF, a count byte
//   and a value byte give one response with the value and the run length,
//   which may be zero. Output is capped at out_capacity bytes: a run is cut
//   to the space left, and once full further bytes are dropped. The word
//   flagged last_byte always gives a response with stream_end set and the
//   total written, then the stream state clears.
//   csr_chan writes out_capacity; it is always ready. The user writes it
//   only while the decoder is idle; the block itself does not enforce this.
//   A request passes through the input register, then the decode step, into
//   the result register. Throughput is one word per cycle while the receiver
//   keeps up, set by the single decode step between the two registers. A
//   stalled receiver holds the result register; the input register takes one
//   more word, then req_chan.ready drops.
//   Reset empties both registers, clears the stream state and sets
//   out_capacity to 33554432.
module escape_rle_byte_decoder #(
   parameter int COUNT_WIDTH = 26
) (
   input  logic         clock,
   input  logic         reset,
   escrle_chan_if.sink   req_chan,
   escrle_chan_if.source rsp_chan,
   escrle_chan_if.sink   csr_chan
);
   import escrle_pkg::*;

   logic         in_valid;
   req_word_type in_word;
   logic         out_free;
   logic         fire;
   step_type     step;

   // Configuration is taken at once
   assign csr_chan.ready = 1'b1;

   // Advance when the input register holds a word and the result slot is free
   assign fire = in_valid && out_free;

   escrle_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_word    (req_chan.data),
      .in_ready   (req_chan.ready),
      .take       (fire),
      .held_valid (in_valid),
      .held_word  (in_word)
   );

   escrle_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_chan.valid && csr_chan.ready),
      .csr_data  (csr_chan.data),
      .fire      (fire),
      .item      (in_word),
      .step      (step)
   );

   escrle_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (fire && step.emit),
      .load_word (step.word),
      .free      (out_free),
      .out_valid (rsp_chan.valid),
      .out_word  (rsp_chan.data),
      .out_ready (rsp_chan.ready)
   );

   // A last byte always produces an end-of-stream response
   assert property (@(posedge clock) disable iff (reset)
      fire && in_word.last_byte |=> rsp_chan.valid && rsp_chan.data.stream_end)
      else $error("last byte gave no end-of-stream response");

   // The running total always covers the run just written
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         rsp_chan.data.total_written >= TotalWidth'(rsp_chan.data.run_length))
      else $error("total written below run length");

   // Back-pressure on requests only with a word waiting in the input register
   assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> in_valid && !out_free)
      else $error("request channel stalled without cause");

endmodule

// File: sim/escape_rle_byte_decoder_tb.sv
// Self-checking testbench for the escape run-length byte decoder.
module escape_rle_byte_decoder_tb;
   import escrle_pkg::*;

   typedef enum logic [1:0] {
      PhaseLiteral = 2'd0,
      PhaseCount   = 2'd1,
      PhaseValue   = 2'd2
   } parse_phase_type;

   localparam logic [CapWidth-1:0] CapMax = CapReset[CapWidth-1:0];
   localparam int DrainCycles = 4;

   logic clock;
   logic reset;

   escrle_chan_if #(.payload_type(req_word_type)) req_if ();
   escrle_chan_if #(.payload_type(rsp_word_type)) rsp_if ();
   escrle_chan_if #(.payload_type(csr_word_type)) csr_if ();

   escape_rle_byte_decoder u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // Decoder state as the testbench sees it
   logic [CapWidth-1:0]   capacity_now;
   logic [CapWidth-1:0]   written_now;
   logic [ByteWidth-1:0]  count_now;
   parse_phase_type       phase_now;
   rsp_word_type          pending_runs[$];

   int req_idle_pct;
   int rsp_stall_pct;
   int rsp_hold_left;
   int words_sent;
   int mismatch_count;

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Print one mismatch line and count it
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   // Work out the response word, if any, for one accepted request word
   task automatic decode_byte(input logic [ByteWidth-1:0] in_byte, input logic last_byte);
      logic                  emit;
      logic [CapWidth-1:0]   room;
      logic [CapWidth-1:0]   run;
      logic [ByteWidth-1:0]  value;
      rsp_word_type          word;
      emit  = 1'b0;
      run   = '0;
      value = '0;
      if (written_now < capacity_now) begin
         case (phase_now)
            PhaseCount: begin
               count_now = in_byte;
               phase_now = PhaseValue;
            end
            PhaseValue: begin
               room        = capacity_now - written_now;
               run         = (CapWidth'(count_now) < room) ? CapWidth'(count_now) : room;
               value       = in_byte;
               written_now = written_now + run;
               phase_now   = PhaseLiteral;
               emit        = 1'b1;
            end
            default: begin
               if (in_byte == EscapeByte) begin
                  phase_now = PhaseCount;
               end else begin
                  value       = in_byte;
                  run         = CapWidth'(1);
                  written_now = written_now + CapWidth'(1);
                  phase_now   = PhaseLiteral;
                  emit        = 1'b1;
               end
            end
         endcase
      end
      if (emit || last_byte) begin
         word.out_value     = value;
         word.run_length    = run[ByteWidth-1:0];
         word.total_written = written_now;
         word.stream_end    = last_byte;
         pending_runs.push_back(word);
      end
      // Clear the stream on its last word
      if (last_byte) begin
         phase_now   = PhaseLiteral;
         count_now   = '0;
         written_now = '0;
      end
   endtask

   // Offer one request word, with random idle cycles ahead of it
   task automatic send_word(input logic [ByteWidth-1:0] in_byte, input logic last_byte);
      while (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
      @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.data  <= '{in_byte: in_byte, last_byte: last_byte};
      do @(posedge clock); while (!req_if.ready);
      decode_byte(in_byte, last_byte);
      words_sent++;
   endtask

   // Drop valid, wait for every response, then let the pipeline settle
   task automatic wait_for_idle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_runs.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Write the output capacity register; call only while idle
   task automatic write_capacity(input logic [CapWidth-1:0] capacity);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.data  <= capacity;
      do @(posedge clock); while (!csr_if.ready);
      capacity_now = capacity;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Send one stream: literals, escapes and noise, sometimes cut mid-escape
   task automatic send_random_stream();
      logic [ByteWidth-1:0] stream_bytes[$];
      int target_len;
      int pick;
      int k;
      target_len = $urandom_range(1, 24);
      while (stream_bytes.size() < target_len) begin
         pick = $urandom_range(99);
         if (pick < 50) begin
            stream_bytes.push_back(ByteWidth'($urandom_range(0, 254)));
         end else if (pick < 90) begin
            stream_bytes.push_back(EscapeByte);
            pick = $urandom_range(99);
            if (pick < 20)
               stream_bytes.push_back(8'd0);
            else if (pick < 40)
               stream_bytes.push_back(8'd255);
            else
               stream_bytes.push_back(ByteWidth'($urandom_range(0, 255)));
            stream_bytes.push_back(ByteWidth'($urandom_range(0, 255)));
         end else begin
            stream_bytes.push_back(ByteWidth'($urandom_range(0, 255)));
         end
      end
      // Cut some streams short, which can leave an escape open
      if ($urandom_range(99) < 15 && stream_bytes.size() > 1)
         stream_bytes = stream_bytes[0:$urandom_range(0, stream_bytes.size() - 2)];
      for (k = 0; k < stream_bytes.size(); k++)
         send_word(stream_bytes[k], k == stream_bytes.size() - 1);
   endtask

   // Literals at the byte extremes, zero and full-length runs, escaped 0xFF
   task automatic test_literals_and_runs();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      send_word(8'h00, 1'b0);
      send_word(8'h7F, 1'b0);
      send_word(8'hFE, 1'b0);
      send_word(EscapeByte, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'h5A, 1'b0);
      send_word(EscapeByte, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(EscapeByte, 1'b0);
      send_word(8'h01, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'h80, 1'b1);
   endtask

   // End markers on an escape byte and on a count byte
   task automatic test_end_markers();
      send_word(EscapeByte, 1'b1);
      send_word(EscapeByte, 1'b0);
      send_word(8'h03, 1'b1);
   endtask

   // Zero capacity, a run cut to the space left, input dropped once full
   task automatic test_capacity_limits();
      wait_for_idle();
      write_capacity('0);
      send_word(8'h41, 1'b0);
      send_word(EscapeByte, 1'b1);
      wait_for_idle();
      write_capacity(CapWidth'(5));
      send_word(8'h01, 1'b0);
      send_word(8'h02, 1'b0);
      send_word(EscapeByte, 1'b0);
      send_word(8'hC8, 1'b0);
      send_word(8'h33, 1'b0);
      send_word(8'h44, 1'b0);
      send_word(EscapeByte, 1'b0);
      send_word(8'h10, 1'b1);
   endtask

   // One phase of random streams under a given idling mix and capacity
   task automatic test_random_streams(input int word_budget, input int idle_pct,
                                      input int stall_pct,
                                      input logic [CapWidth-1:0] capacity);
      int stop_at;
      wait_for_idle();
      write_capacity(capacity);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      stop_at       = words_sent + word_budget;
      while (words_sent < stop_at)
         send_random_stream();
   endtask

   // Hold the receiver off long enough to fill the decoder, then pause mid-stream
   task automatic test_backpressure();
      int stop_at;
      wait_for_idle();
      write_capacity(CapMax);
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      rsp_hold_left = 150;
      stop_at       = words_sent + 40;
      while (words_sent < stop_at)
         send_random_stream();
      send_word(8'h21, 1'b0);
      send_word(EscapeByte, 1'b0);
      wait_for_idle();
      send_word(8'h09, 1'b0);
      send_word(8'hC3, 1'b1);
   endtask

   // Receiver: stall at random, or hold off for a counted stretch
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
         rsp_if.ready  <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Compare each accepted response word with the oldest expectation
   always @(posedge clock) begin : check_words
      rsp_word_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_runs.size() == 0) begin
            report_mismatch("unexpected response word, total_written",
                            32'(rsp_if.data.total_written), 32'd0);
         end else begin
            want = pending_runs.pop_front();
            if (rsp_if.data.out_value !== want.out_value)
               report_mismatch("out_value", 32'(rsp_if.data.out_value),
                               32'(want.out_value));
            if (rsp_if.data.run_length !== want.run_length)
               report_mismatch("run_length", 32'(rsp_if.data.run_length),
                               32'(want.run_length));
            if (rsp_if.data.total_written !== want.total_written)
               report_mismatch("total_written", 32'(rsp_if.data.total_written),
                               32'(want.total_written));
            if (rsp_if.data.stream_end !== want.stream_end)
               report_mismatch("stream_end", 32'(rsp_if.data.stream_end),
                               32'(want.stream_end));
         end
      end
   end

   // Give up after a generous fixed time
   initial begin
      #3000000;
      $display("escape_rle_byte_decoder_tb: FAIL");
      $finish;
   end

   // Main sequence
   initial begin
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.data    = '0;
      rsp_if.ready   = 1'b0;
      csr_if.valid   = 1'b0;
      csr_if.data    = '0;
      req_idle_pct   = 0;
      rsp_stall_pct  = 0;
      rsp_hold_left  = 0;
      words_sent     = 0;
      mismatch_count = 0;
      capacity_now   = CapMax;
      written_now    = '0;
      count_now      = '0;
      phase_now      = PhaseLiteral;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_literals_and_runs();
      test_end_markers();
      test_capacity_limits();
      test_random_streams(200, 0, 0, CapMax);
      test_random_streams(200, 51, 0, CapWidth'($urandom_range(1, 400)));
      test_random_streams(200, 0, 51, CapWidth'($urandom_range(1 << 24, 33554432)));
      test_random_streams(200, 8, 8, CapWidth'($urandom_range(0, 3000)));
      test_backpressure();
      wait_for_idle();

      if (mismatch_count == 0)
         $display("escape_rle_byte_decoder_tb: PASS");
      else
         $display("escape_rle_byte_decoder_tb: FAIL");
      $finish;
   end

endmodule

// File: files.f
sv/escrle_pkg.sv
sv/escrle_chan_if.sv
sv/escrle_in_reg.sv
sv/escrle_core.sv
sv/escrle_out_reg.sv
sv/escape_rle_byte_decoder.sv
sim/escape_rle_byte_decoder_tb.sv
